FILE: rtl/roberts_cross_edge_magnitude_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef ROBERTS_CROSS_EDGE_MAGNITUDE_ASSERT_SVH
`define ROBERTS_CROSS_EDGE_MAGNITUDE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCEM_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCEM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/rcem_pkg.sv
package rcem_pkg;

    localparam int PIX_W = 8;
    typedef logic [PIX_W-1:0] pixel_t;

    localparam int CFG_W_BITS = 11;
    localparam int CFG_H_BITS = 13;
    localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 13'd4096;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [1:0] job_t;
    localparam job_t JOB_DIAG   = 2'd0;
    localparam job_t JOB_RIGHT  = 2'd1;
    localparam job_t JOB_BOTTOM = 2'd2;
    localparam job_t JOB_CORNER = 2'd3;

    typedef struct packed {
        logic   start;
        pixel_t dx;
        pixel_t dy;
    } mag_req_t;

    typedef struct packed {
        logic   done;
        pixel_t mag;
    } mag_rsp_t;

endpackage

FILE: rtl/roberts_cross_edge_magnitude.sv
// Roberts cross edge magnitude over a raster pixel stream.
// s_ channel: one 8-bit pixel per transfer, rows left to right, top to bottom.
// m_ channel: edge magnitudes; tlast ends the run of results caused by one
// pixel, tuser marks the final result of the frame. A pixel causes zero to
// four results; results of the last column and the last row follow as runs.
// APB port: image_width at 0x0, image_height at 0x4; a write restarts the
// frame position. Write only while the block is idle.
// Sequencing: a pixel with no result frees the input after the READ and PICK states;
// each magnitude result passes through PICK, squaring and a two-bits-per-cycle
// square root (SQRT), then EMIT; the bottom-right zero skips the square root.
// The first result passes READ, PICK, SQRT and EMIT before the output register.
// The prior row sits in a single-port read-first line buffer read and written
// in the transfer cycle.
// Reset clears the frame position and neighbour registers and drops m_tvalid.
// When the receiver stalls, the result holds in the output register; the
// next pixel is still taken, and later results wait until the register frees.
`include "roberts_cross_edge_magnitude_assert.svh"
module roberts_cross_edge_magnitude #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] edge_magnitude
    output logic        m_tlast,
    output logic        m_tuser,   // [0] frame_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rcem_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_PICK = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    function automatic pixel_t absdiff(pixel_t a, pixel_t b);
        return (a >= b) ? pixel_t'(a - b) : pixel_t'(b - a);
    endfunction

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [CFG_W_BITS-1:0] width_reg;
    logic [CFG_H_BITS-1:0] height_reg;
    logic [COL_W-1:0]      col_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [COL_W-1:0]      w_last;
    logic [ROW_W-1:0]      h_last;
    logic                  at_last_col;
    logic                  at_last_row;
    pixel_t                left_reg;
    pixel_t                ul_reg;
    pixel_t                cur_reg;
    logic                  col_nz_reg;
    logic                  row_nz_reg;
    logic                  last_col_reg;
    logic                  last_row_reg;
    logic [3:0]            job_mask_reg;
    logic [3:0]            rest;
    job_t                  job_reg;
    job_t                  pick;
    pixel_t                dxa_reg;
    pixel_t                dya_reg;
    pixel_t                db_reg;
    pixel_t                dc_reg;
    pixel_t                mag_reg;
    pixel_t                up;
    logic                  m_tvalid_reg;
    pixel_t                m_tdata_reg;
    logic                  m_tlast_reg;
    logic                  m_tuser_reg;
    logic                  in_xfer;
    logic                  cfg_wr;
    logic                  out_free;
    mag_req_t              mreq;
    mag_rsp_t              mrsp;

    assign in_xfer  = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_IMAGE_WIDTH) ? 32'(width_reg) : 32'(height_reg);

    always_comb begin
        if (width_reg == '0) begin
            w_last = '0;
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_last = COL_W'(width_reg - 11'd1);
        end
        if (height_reg == '0) begin
            h_last = '0;
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            h_last = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            h_last = ROW_W'(height_reg - 13'd1);
        end
    end

    assign at_last_col = (col_reg == w_last);
    assign at_last_row = (row_reg == h_last);

    rcem_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_buf (
        .aclk     (aclk),
        .acc_en   (in_xfer),
        .acc_addr (col_reg),
        .wr_data  (s_tdata),
        .rd_data  (up)
    );

    always_comb begin
        if (job_mask_reg[0]) begin
            pick = JOB_DIAG;
        end else if (job_mask_reg[1]) begin
            pick = JOB_RIGHT;
        end else if (job_mask_reg[2]) begin
            pick = JOB_BOTTOM;
        end else begin
            pick = JOB_CORNER;
        end
    end

    always_comb begin
        mreq.start = (state_reg == S_PICK) && (job_mask_reg != 4'b0) && (pick != JOB_CORNER);
        case (pick)
            JOB_DIAG: begin
                mreq.dx = dxa_reg;
                mreq.dy = dya_reg;
            end
            JOB_RIGHT: begin
                mreq.dx = db_reg;
                mreq.dy = db_reg;
            end
            default: begin
                mreq.dx = dc_reg;
                mreq.dy = dc_reg;
            end
        endcase
    end

    rcem_mag u_mag (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    assign rest = job_mask_reg & ~(4'b0001 << job_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_xfer) state_next = S_READ;
            end
            S_READ: begin
                state_next = S_PICK;
            end
            S_PICK: begin
                if (job_mask_reg == 4'b0) begin
                    state_next = S_IDLE;
                end else if (pick == JOB_CORNER) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                if (mrsp.done) state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) state_next = S_PICK;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            ul_reg       <= '0;
            job_mask_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                if (paddr[2] == REG_IMAGE_WIDTH) begin
                    width_reg <= pwdata[CFG_W_BITS-1:0];
                end else begin
                    height_reg <= pwdata[CFG_H_BITS-1:0];
                end
                col_reg  <= '0;
                row_reg  <= '0;
                left_reg <= '0;
                ul_reg   <= '0;
            end
            if (in_xfer) begin
                cur_reg      <= s_tdata;
                col_nz_reg   <= (col_reg != '0);
                row_nz_reg   <= (row_reg != '0);
                last_col_reg <= at_last_col;
                last_row_reg <= at_last_row;
                if (at_last_col) begin
                    col_reg <= '0;
                    row_reg <= at_last_row ? '0 : row_reg + ROW_W'(1);
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
            if (state_reg == S_READ) begin
                dxa_reg      <= absdiff(ul_reg, cur_reg);
                dya_reg      <= absdiff(up, left_reg);
                db_reg       <= absdiff(up, cur_reg);
                dc_reg       <= absdiff(left_reg, cur_reg);
                job_mask_reg <= {last_row_reg && last_col_reg, last_row_reg && col_nz_reg,
                                 row_nz_reg && last_col_reg, row_nz_reg && col_nz_reg};
                left_reg     <= cur_reg;
                ul_reg       <= up;
            end
            if (state_reg == S_PICK && job_mask_reg != 4'b0) begin
                job_reg <= pick;
                if (pick == JOB_CORNER) mag_reg <= '0;
            end
            if (state_reg == S_SQRT && mrsp.done) begin
                mag_reg <= mrsp.mag;
            end
            if (state_reg == S_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= mag_reg;
                m_tlast_reg  <= (rest == 4'b0);
                m_tuser_reg  <= (rest == 4'b0) && last_row_reg && last_col_reg;
                job_mask_reg <= rest;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    `RCEM_ASSERT_NEXT(a_accept_to_read, aclk, aresetn, in_xfer, state_reg == S_READ)
    `RCEM_ASSERT_SAME(a_ready_no_jobs, aclk, aresetn, s_tready, job_mask_reg == 4'b0)
    `RCEM_ASSERT_NEXT(a_pick_dispatch, aclk, aresetn, state_reg == S_PICK && job_mask_reg != 4'b0, state_reg == S_SQRT || state_reg == S_EMIT)
    `RCEM_ASSERT_SAME(a_frame_done_last, aclk, aresetn, m_tvalid_reg && m_tuser_reg, m_tlast_reg)

endmodule

FILE: rtl/rcem_line_buf.sv
module rcem_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              aclk,
    input  logic              acc_en,
    input  logic [AW-1:0]     acc_addr,
    input  rcem_pkg::pixel_t  wr_data,
    output rcem_pkg::pixel_t  rd_data
);
    import rcem_pkg::*;

    pixel_t mem [DEPTH];
    pixel_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (acc_en) begin
            rd_data_reg    <= mem[acc_addr];
            mem[acc_addr]  <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/rcem_mag.sv
module rcem_mag (
    input  logic               aclk,
    input  logic               aresetn,
    input  rcem_pkg::mag_req_t req,
    output rcem_pkg::mag_rsp_t rsp
);
    import rcem_pkg::*;

    typedef struct packed {
        logic [7:0] root;
        logic [8:0] rem;
    } step_t;

    function automatic step_t sq_step(logic [7:0] r, logic [8:0] m, logic [1:0] b);
        logic [10:0] w;
        logic [10:0] t;
        step_t       o;
        w = {m, b};
        t = {1'b0, r, 2'b01};
        if (w >= t) begin
            o.rem  = 9'(w - t);
            o.root = {r[6:0], 1'b1};
        end else begin
            o.rem  = 9'(w);
            o.root = {r[6:0], 1'b0};
        end
        return o;
    endfunction

    logic [15:0] sq_x;
    logic [15:0] sq_y;
    logic [16:0] sum;
    logic        busy_reg;
    logic        done_reg;
    logic [1:0]  cnt_reg;
    logic [15:0] rad_reg;
    logic        sat_reg;
    logic [7:0]  root_reg;
    logic [8:0]  rem_reg;
    step_t       s1;
    step_t       s2;

    always_comb begin
        sq_x = 16'(req.dx) * 16'(req.dx);
        sq_y = 16'(req.dy) * 16'(req.dy);
        sum  = {1'b0, sq_x} + {1'b0, sq_y};
        s1   = sq_step(root_reg, rem_reg, rad_reg[15:14]);
        s2   = sq_step(s1.root, s1.rem, rad_reg[13:12]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rad_reg  <= sum[15:0];
                sat_reg  <= sum[16];
                root_reg <= '0;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rad_reg  <= {rad_reg[11:0], 4'b0000};
                root_reg <= s2.root;
                rem_reg  <= s2.rem;
                cnt_reg  <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.mag  = sat_reg ? '1 : root_reg;

endmodule

FILE: tb/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rcem_pkg::*;

    localparam int MAX_W = 1024;
    localparam int MAX_H = 4096;
    localparam int DRAIN_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [7:0] mag;
        logic       last;
        logic       done;
    } edge_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [7:0] pixel_value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] edge_magnitude
    logic        m_tlast;
    logic        m_tuser;         // [0] frame_done
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    roberts_cross_edge_magnitude u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Edge predictor state
    logic [CFG_W_BITS-1:0] cfg_width = WIDTH_RESET;
    logic [CFG_H_BITS-1:0] cfg_height = HEIGHT_RESET;
    pixel_t      row_above [MAX_W];
    pixel_t      west_pix = '0;
    pixel_t      northwest_pix = '0;
    int unsigned cur_col = 0;
    int unsigned cur_row = 0;

    pixel_t       pending_pixels [$];
    edge_result_t expected_edges [$];

    int  errors = 0;
    int  pixels_sent = 0;
    int  edges_checked = 0;
    int  settings_used = 0;
    bit  idle_mode = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  quiet_cycles = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic pixel_t edge_mag(input pixel_t a, input pixel_t b,
                                        input pixel_t c, input pixel_t d);
        int dx;
        int dy;
        int energy;
        int r;
        dx = (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
        dy = (c >= d) ? int'(c) - int'(d) : int'(d) - int'(c);
        energy = dx * dx + dy * dy;
        r = 0;
        while (r < 255 && (r + 1) * (r + 1) <= energy) r++;
        return pixel_t'(r);
    endfunction

    task automatic predict_edges(input pixel_t cur);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        pixel_t up;
        bit lc;
        bit lr;
        pixel_t mags [4];
        int n;
        edge_result_t res;
        w = clamp_dim(cfg_width, MAX_W);
        h = clamp_dim(cfg_height, MAX_H);
        c = (cur_col >= w) ? w - 1 : cur_col;
        r = (cur_row >= h) ? h - 1 : cur_row;
        lc = (c == w - 1);
        lr = (r == h - 1);
        up = row_above[c];
        n = 0;
        if (r >= 1) begin
            if (c >= 1) begin
                mags[n] = edge_mag(northwest_pix, cur, up, west_pix);
                n++;
            end
            if (lc) begin
                mags[n] = edge_mag(up, cur, up, cur);
                n++;
            end
        end
        if (lr) begin
            if (c >= 1) begin
                mags[n] = edge_mag(west_pix, cur, cur, west_pix);
                n++;
            end
            if (lc) begin
                mags[n] = '0;
                n++;
            end
        end
        for (int k = 0; k < n; k++) begin
            res.mag = mags[k];
            res.last = (k == n - 1);
            res.done = (k == n - 1) && lr && lc;
            expected_edges.push_back(res);
        end
        northwest_pix = up;
        row_above[c] = cur;
        west_pix = cur;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        cur_col = c;
        cur_row = r;
    endtask

    // Pixel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_edges(s_tdata);
                pixels_sent++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the pending transfer
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                s_tdata <= pending_pixels.pop_front();
                s_tvalid <= 1'b1;
                send_gap = idle_mode ? pick_gap() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        edge_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_edges.size() == 0) begin
                    $display("%0t unexpected result: got mag %0d last %0b done %0b",
                             $time, m_tdata, m_tlast, m_tuser);
                    errors++;
                end else begin
                    want = expected_edges.pop_front();
                    edges_checked++;
                    if (m_tdata !== want.mag) begin
                        $display("%0t edge_magnitude mismatch: expected %0d, got %0d",
                                 $time, want.mag, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t last_of_run mismatch: expected %0b, got %0b",
                                 $time, want.last, m_tlast);
                        errors++;
                    end
                    if (m_tuser !== want.done) begin
                        $display("%0t frame_done mismatch: expected %0b, got %0b",
                                 $time, want.done, m_tuser);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idle_mode && $urandom_range(0, 3) == 0) recv_gap = pick_gap();
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, quiet_cycles);
            $display("roberts_cross_edge_magnitude test failed");
            $finish;
        end
    end

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_pixels.size() != 0 || s_tvalid || expected_edges.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic reg_read_check(input logic idx, input logic [31:0] want);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        if (prdata !== want) begin
            $display("%0t register %0d readback mismatch: expected %0h, got %0h",
                     $time, idx, want, prdata);
            errors++;
        end
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) cfg_width = value[CFG_W_BITS-1:0];
        else cfg_height = value[CFG_H_BITS-1:0];
        cur_col = 0;
        cur_row = 0;
        west_pix = '0;
        northwest_pix = '0;
        if (idx == REG_IMAGE_WIDTH) reg_read_check(idx, 32'(cfg_width));
        else reg_read_check(idx, 32'(cfg_height));
    endtask

    task automatic set_frame_size(input int unsigned w, input int unsigned h);
        logic [31:0] wv;
        logic [31:0] hv;
        wv = 32'(w);
        hv = 32'(h);
        // junk in the unused upper bits now and then
        if ($urandom_range(0, 1)) wv = ($urandom() & ~32'h7FF) | (wv & 32'h7FF);
        if ($urandom_range(0, 1)) hv = ($urandom() & ~32'h1FFF) | (hv & 32'h1FFF);
        wait_drained();
        reg_write(REG_IMAGE_WIDTH, wv);
        reg_write(REG_IMAGE_HEIGHT, hv);
        settings_used++;
    endtask

    function automatic pixel_t next_pixel(input pixel_t prev);
        int d;
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            1: begin
                d = int'(prev) + $urandom_range(0, 16) - 8;
                if (d < 0) d = 0;
                if (d > 255) d = 255;
                return pixel_t'(d);
            end
            default: return pixel_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_random(input int n);
        pixel_t p;
        p = pixel_t'($urandom_range(0, 255));
        for (int i = 0; i < n; i++) begin
            p = next_pixel(p);
            pending_pixels.push_back(p);
        end
    endtask

    initial begin
        pixel_t directed_a [] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255,
                                  8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd17, 8'd200};
        pixel_t directed_b [] = '{8'd10, 8'd13, 8'd7, 8'd20, 8'd9, 8'd30};
        int random_pixels;
        int w;
        int h;
        int n;

        foreach (row_above[i]) row_above[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        reg_read_check(REG_IMAGE_WIDTH, 32'(WIDTH_RESET));
        reg_read_check(REG_IMAGE_HEIGHT, 32'(HEIGHT_RESET));

        // one full 4x3 frame of extremes, then into the next frame
        idle_mode = 1'b0;
        set_frame_size(4, 3);
        foreach (directed_a[i]) pending_pixels.push_back(directed_a[i]);
        set_frame_size(3, 2);
        idle_mode = 1'b1;
        foreach (directed_b[i]) pending_pixels.push_back(directed_b[i]);

        // zero sizes, single row or column, maximum and oversized sizes
        random_pixels = 0;
        set_frame_size(0, 0);
        push_random(8);
        set_frame_size(1, 6);
        push_random(14);
        set_frame_size(6, 1);
        push_random(14);
        set_frame_size(1024, 1);
        push_random(30);
        set_frame_size(2047, 1);
        push_random(20);
        set_frame_size(1, 4096);
        push_random(20);
        set_frame_size(3, 8191);
        push_random(24);
        set_frame_size(2, 2);
        push_random(12);
        random_pixels = 162;

        while (random_pixels < 262) begin
            w = $urandom_range(1, 7);
            h = $urandom_range(1, 6);
            n = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
            idle_mode = ($urandom_range(0, 3) != 0);
            set_frame_size(w, h);
            push_random(n);
            random_pixels += n;
        end

        wait_drained();
        $display("sent %0d pixels over %0d frame sizes (zero, single, max and oversized)",
                 pixels_sent, settings_used);
        $display("checked %0d edge results with stalls on both sides", edges_checked);
        if (errors == 0) begin
            $display("roberts_cross_edge_magnitude test passed");
        end else begin
            $display("roberts_cross_edge_magnitude test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
